// ===== rtl/assert_macros.svh =====
// Assertion macros used by the parser unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/nmea_pkg.sv =====
// Types, character codes and helpers for the NMEA sentence parser.
`default_nettype none

package nmea_pkg;

  // Field index at which a field byte aborts the sentence.
  localparam logic [3:0] FIELD_LIMIT = 4'd11;
  localparam logic [3:0] FIELD_POS_MAX = 4'd15;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] CHAR_N      = 8'h4E;
  localparam logic [7:0] CHAR_S      = 8'h53;
  localparam logic [7:0] CHAR_E      = 8'h45;
  localparam logic [7:0] CHAR_W      = 8'h57;
  localparam logic [7:0] CHAR_C      = 8'h43;
  localparam logic [7:0] CHAR_Z      = 8'h5A;
  localparam logic [7:0] CHAR_V      = 8'h56;
  localparam logic [7:0] CHAR_A      = 8'h41;
  localparam logic [7:0] CHAR_ONE    = 8'h31;
  localparam logic [7:0] CHAR_TWO    = 8'h32;
  localparam logic [7:0] CHAR_THREE  = 8'h33;

  localparam logic [7:0] HEX_BASE  = 8'd48;
  localparam logic [7:0] HEX_GAP   = 8'd7;
  localparam logic [7:0] HEX_DIGIT_MAX = 8'd9;

  // Comma counts that select a field.
  localparam logic [7:0] GGA_LAT_FIELD     = 8'd2;
  localparam logic [7:0] GGA_LAT_HEM_FIELD = 8'd3;
  localparam logic [7:0] GGA_LON_FIELD     = 8'd4;
  localparam logic [7:0] GGA_LON_HEM_FIELD = 8'd5;
  localparam logic [7:0] GGA_QUAL_FIELD    = 8'd6;
  localparam logic [7:0] GGA_SATS_FIELD    = 8'd7;
  localparam logic [7:0] GGA_END_FIELD     = 8'd15;
  localparam logic [7:0] RMC_SPEED_FIELD   = 8'd7;
  localparam logic [7:0] RMC_COURSE_FIELD  = 8'd8;
  localparam logic [7:0] RMC_END_FIELD     = 8'd13;

  // Checksum phases.
  localparam logic [7:0] PHASE_DATA = 8'd0;
  localparam logic [7:0] PHASE_HIGH = 8'd1;
  localparam logic [7:0] PHASE_LOW  = 8'd2;
  localparam logic [7:0] PHASE_DONE = 8'd3;

  // Buffer positions that the GGA layout check looks at.
  localparam logic [3:0] LAT_DOT_POS = 4'd4;
  localparam logic [3:0] LAT_HEM_POS = 4'd7;
  localparam logic [3:0] LON_DOT_POS = 4'd5;
  localparam logic [3:0] LON_HEM_POS = 4'd8;

  typedef enum logic [1:0] {
    KIND_UNKNOWN = 2'd0,
    KIND_IGNORED = 2'd1,
    KIND_GGA     = 2'd2,
    KIND_RMC     = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    TGT_NONE    = 3'd0,
    TGT_LAT     = 3'd1,
    TGT_LAT_HEM = 3'd2,
    TGT_LON     = 3'd3,
    TGT_LON_HEM = 3'd4,
    TGT_SATS    = 3'd5,
    TGT_SPEED   = 3'd6,
    TGT_COURSE  = 3'd7
  } target_t;

  typedef struct packed {
    kind_t       kind;
    logic        checked;
    logic        match;
    logic        gga_valid;
    logic        rmc_valid;
    target_t     target;
    logic [3:0]  pos;
    logic [7:0]  ch;
  } result_t;

  // Hex digit value, no range check; wraps mod 256.
  function automatic logic [7:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    d = c - HEX_BASE;
    if (d > HEX_DIGIT_MAX) d = d - HEX_GAP;
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/nmea_sentence_parser_unit.sv =====
// NMEA 0183 sentence parser: one byte in, one status result out.
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------------
//   in      | in_valid/in_ready  | rx_byte, line_error, clear_flags
//   out     | out_valid/out_ready| sentence_kind, checksum_checked/_match,
//           |                    | gga_valid, rmc_valid, store_target/_position/_char
//
// One byte is accepted per cycle while in_ready is high; its result is registered.
// All parsing for a byte is one combinational pass from the parser state registers.
// A two-entry output buffer (result register plus skid register) keeps in_ready
// high for one extra byte while out_ready is low; in_ready is the inverted skid valid.
// Synchronous reset clears the parser state, the four checked buffer characters
// and both output valids.
`default_nettype none

`include "assert_macros.svh"

module nmea_sentence_parser_unit
  import nmea_pkg::*;
#(
  parameter logic [3:0] FIELD_CHARS_MAX = FIELD_LIMIT
)
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  input  wire logic       line_error,
  input  wire logic       clear_flags,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      sentence_kind,
  output logic            checksum_checked,
  output logic            checksum_match,
  output logic            gga_valid,
  output logic            rmc_valid,
  output logic [2:0]      store_target,
  output logic [3:0]      store_position,
  output logic [7:0]      store_char
);

  // Parser state
  kind_t      kind;
  logic [7:0] comma_count;
  logic [3:0] field_pos;
  logic [7:0] checksum_phase;
  logic [7:0] running_xor;
  logic [7:0] received_sum;
  logic       quality_ok;
  logic       gga_ok;
  logic       rmc_ok;
  // Only these buffer characters are ever read back.
  logic [7:0] lat_dot;
  logic [7:0] lat_hem;
  logic [7:0] lon_dot;
  logic [7:0] lon_hem;

  kind_t      kind_next;
  logic [7:0] comma_count_next;
  logic [3:0] field_pos_next;
  logic [7:0] checksum_phase_next;
  logic [7:0] running_xor_next;
  logic [7:0] received_sum_next;
  logic       quality_ok_next;
  logic       gga_ok_next;
  logic       rmc_ok_next;
  logic [7:0] lat_dot_next;
  logic [7:0] lat_hem_next;
  logic [7:0] lon_dot_next;
  logic [7:0] lon_hem_next;

  logic [7:0] c;
  logic [7:0] digit;
  logic [7:0] sum_low;
  logic [3:0] pos_inc;
  logic       layout_ok;
  result_t    res;

  // Output buffer
  logic    in_xfer;
  logic    skid_valid;
  result_t out_res;
  result_t skid_res;

  // Assertion terms
  logic chk_drain;
  logic chk_match;
  logic chk_idle;
  logic chk_zero;

  assign in_ready = !skid_valid;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    kind_next           = kind;
    comma_count_next    = comma_count;
    field_pos_next      = field_pos;
    checksum_phase_next = checksum_phase;
    running_xor_next    = running_xor;
    received_sum_next   = received_sum;
    quality_ok_next     = quality_ok;
    gga_ok_next         = gga_ok;
    rmc_ok_next         = rmc_ok;
    lat_dot_next        = lat_dot;
    lat_hem_next        = lat_hem;
    lon_dot_next        = lon_dot;
    lon_hem_next        = lon_hem;

    c       = line_error ? CHAR_DOLLAR : rx_byte;
    digit   = hex_value(c);
    sum_low = received_sum + digit;
    pos_inc = (field_pos != FIELD_POS_MAX) ? field_pos + 4'd1 : field_pos;
    layout_ok = (lat_dot == CHAR_DOT) && (lon_dot == CHAR_DOT) && quality_ok &&
                ((lat_hem == CHAR_N) || (lat_hem == CHAR_S)) &&
                ((lon_hem == CHAR_E) || (lon_hem == CHAR_W));

    res = '0;

    if (clear_flags || line_error) begin
      gga_ok_next = 1'b0;
      rmc_ok_next = 1'b0;
    end

    priority if (c == CHAR_DOLLAR) begin
      comma_count_next    = '0;
      kind_next           = KIND_UNKNOWN;
      running_xor_next    = '0;
      checksum_phase_next = PHASE_DATA;
      quality_ok_next     = 1'b0;
    end else if (c == CHAR_STAR) begin
      checksum_phase_next = checksum_phase + 8'd1;
    end else begin
      if (checksum_phase == PHASE_DATA) running_xor_next = running_xor ^ c;

      if (c == CHAR_COMMA) begin
        comma_count_next = comma_count + 8'd1;
        field_pos_next   = '0;
      end else if (checksum_phase == PHASE_HIGH) begin
        received_sum_next   = {digit[3:0], 4'b0000};
        checksum_phase_next = PHASE_LOW;
      end else if (checksum_phase == PHASE_LOW) begin
        received_sum_next   = sum_low;
        checksum_phase_next = PHASE_DONE;
        res.checked         = 1'b1;
        if (sum_low == running_xor) begin
          res.match = 1'b1;
          if (kind == KIND_RMC) rmc_ok_next = 1'b1;
          if (kind == KIND_GGA) gga_ok_next = layout_ok;
        end
      end else if (comma_count == '0) begin
        // Sentence ID letters pick the kind
        if (c == CHAR_C) begin
          kind_next = KIND_RMC;
        end else if (c == CHAR_S || c == CHAR_Z || c == CHAR_V) begin
          kind_next = KIND_IGNORED;
        end else if (c == CHAR_A && kind != KIND_IGNORED) begin
          kind_next = KIND_GGA;
        end
      end else if (field_pos == FIELD_CHARS_MAX) begin
        kind_next = KIND_UNKNOWN;
      end else if (kind == KIND_RMC) begin
        if (comma_count == RMC_SPEED_FIELD) begin
          res.target = TGT_SPEED;  res.pos = field_pos; res.ch = c;
          field_pos_next = pos_inc;
        end else if (comma_count == RMC_COURSE_FIELD) begin
          res.target = TGT_COURSE; res.pos = field_pos; res.ch = c;
          field_pos_next = pos_inc;
        end else if (comma_count == RMC_END_FIELD) begin
          kind_next = KIND_UNKNOWN;
        end
      end else if (kind == KIND_GGA) begin
        if (comma_count == GGA_LAT_FIELD) begin
          res.target = TGT_LAT; res.pos = field_pos; res.ch = c;
          field_pos_next = pos_inc;
          if (field_pos == LAT_DOT_POS) lat_dot_next = c;
          if (field_pos == LAT_HEM_POS) lat_hem_next = c;
        end else if (comma_count == GGA_LAT_HEM_FIELD) begin
          res.target = TGT_LAT_HEM; res.pos = LAT_HEM_POS; res.ch = c;
          lat_hem_next = c;
        end else if (comma_count == GGA_LON_FIELD) begin
          res.target = TGT_LON; res.pos = field_pos; res.ch = c;
          field_pos_next = pos_inc;
          if (field_pos == LON_DOT_POS) lon_dot_next = c;
          if (field_pos == LON_HEM_POS) lon_hem_next = c;
        end else if (comma_count == GGA_LON_HEM_FIELD) begin
          res.target = TGT_LON_HEM; res.pos = LON_HEM_POS; res.ch = c;
          lon_hem_next = c;
        end else if (comma_count == GGA_QUAL_FIELD) begin
          if (c == CHAR_ONE || c == CHAR_TWO || c == CHAR_THREE) quality_ok_next = 1'b1;
        end else if (comma_count == GGA_SATS_FIELD) begin
          res.target = TGT_SATS; res.pos = field_pos; res.ch = c;
          field_pos_next = pos_inc;
        end else if (comma_count == GGA_END_FIELD) begin
          kind_next = KIND_UNKNOWN;
        end
      end
    end

    res.kind      = kind_next;
    res.gga_valid = gga_ok_next;
    res.rmc_valid = rmc_ok_next;
  end

  // Parser state advances on every input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      kind           <= KIND_UNKNOWN;
      comma_count    <= '0;
      field_pos      <= '0;
      checksum_phase <= PHASE_DATA;
      running_xor    <= '0;
      received_sum   <= '0;
      quality_ok     <= 1'b0;
      gga_ok         <= 1'b0;
      rmc_ok         <= 1'b0;
      lat_dot        <= '0;
      lat_hem        <= '0;
      lon_dot        <= '0;
      lon_hem        <= '0;
    end else if (in_xfer) begin
      kind           <= kind_next;
      comma_count    <= comma_count_next;
      field_pos      <= field_pos_next;
      checksum_phase <= checksum_phase_next;
      running_xor    <= running_xor_next;
      received_sum   <= received_sum_next;
      quality_ok     <= quality_ok_next;
      gga_ok         <= gga_ok_next;
      rmc_ok         <= rmc_ok_next;
      lat_dot        <= lat_dot_next;
      lat_hem        <= lat_hem_next;
      lon_dot        <= lon_dot_next;
      lon_hem        <= lon_hem_next;
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_xfer;
      end
    end else if (in_xfer) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) out_res <= skid_res;
      else if (in_xfer) out_res <= res;
    end else if (in_xfer) begin
      skid_res <= res;
    end
  end

  assign sentence_kind    = out_res.kind;
  assign checksum_checked = out_res.checked;
  assign checksum_match   = out_res.match;
  assign gga_valid        = out_res.gga_valid;
  assign rmc_valid        = out_res.rmc_valid;
  assign store_target     = out_res.target;
  assign store_position   = out_res.pos;
  assign store_char       = out_res.ch;

  assign chk_drain = skid_valid && out_ready;
  assign chk_match = out_valid && checksum_match;
  assign chk_idle  = out_valid && (store_target == TGT_NONE);
  assign chk_zero  = (store_position == 4'd0) && (store_char == 8'd0);

  `ASSERT_SAME(a_skid_behind_out, clk, rst, skid_valid, out_valid, "skid full with output empty")
  `ASSERT_NEXT(a_skid_drains, clk, rst, chk_drain, out_valid && !skid_valid, "skid did not drain")
  `ASSERT_SAME(a_match_needs_check, clk, rst, chk_match, checksum_checked, "match without check")
  `ASSERT_SAME(a_no_store_is_zero, clk, rst, chk_idle, chk_zero, "idle store not zero")

endmodule

`default_nettype wire

// ===== tb/tb_nmea_sentence_parser_unit.sv =====
// Self-checking testbench for the NMEA sentence parser unit.
`default_nettype none

module tb_nmea_sentence_parser_unit;
  import nmea_pkg::*;

  localparam int TEXT_DEPTH = 12;
  localparam int RANDOM_ITEMS = 400;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_ZERO = 8'h30;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] rx_byte;
  logic       line_error;
  logic       clear_flags;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] sentence_kind;
  logic       checksum_checked;
  logic       checksum_match;
  logic       gga_valid;
  logic       rmc_valid;
  logic [2:0] store_target;
  logic [3:0] store_position;
  logic [7:0] store_char;

  nmea_sentence_parser_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .rx_byte(rx_byte), .line_error(line_error), .clear_flags(clear_flags),
    .out_valid(out_valid), .out_ready(out_ready),
    .sentence_kind(sentence_kind), .checksum_checked(checksum_checked),
    .checksum_match(checksum_match), .gga_valid(gga_valid), .rmc_valid(rmc_valid),
    .store_target(store_target), .store_position(store_position), .store_char(store_char)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Parser state as the testbench tracks it.
  kind_t      cur_kind;
  logic [7:0] comma_total;
  logic [3:0] char_index;
  logic [7:0] sum_phase;
  logic [7:0] xor_sum;
  logic [7:0] rx_checksum;
  logic       fix_quality_seen;
  logic       gga_fix;
  logic       rmc_fix;
  logic [7:0] lat_chars [TEXT_DEPTH];
  logic [7:0] lon_chars [TEXT_DEPTH];

  result_t    pending_status [$];
  logic [7:0] frame [$];

  bit sender_idles;
  bit receiver_idles;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int stall_left = 0;
  int cycle_count = 0;

  int bytes_sent = 0;
  int random_bytes = 0;
  int sentence_total = 0;
  int results_checked = 0;
  int mismatch_total = 0;
  int checksum_hits = 0;
  int gga_fixes = 0;
  int rmc_fixes = 0;
  int limit_aborts = 0;

  result_t seen_status;
  result_t want_status;
  string   diff_fields;

  // ---------------------------------------------------------------- prediction

  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    v = c - HEX_BASE;
    return (v > HEX_DIGIT_MAX) ? v - HEX_GAP : v;
  endfunction

  function automatic logic [3:0] take_index();
    logic [3:0] p;
    p = char_index;
    if (char_index < FIELD_POS_MAX) char_index = char_index + 4'd1;
    return p;
  endfunction

  function automatic result_t next_parser_status(input logic [7:0] b, input logic err,
                                                 input logic clr);
    result_t    st;
    logic [7:0] c;
    logic       layout_ok;
    st = '0;
    c = b;
    if (clr || err) begin
      gga_fix = 1'b0;
      rmc_fix = 1'b0;
    end
    // A line error restarts the sentence like a dollar sign.
    if (err) c = CHAR_DOLLAR;
    if (c == CHAR_DOLLAR) begin
      comma_total = '0;
      cur_kind = KIND_UNKNOWN;
      xor_sum = '0;
      sum_phase = PHASE_DATA;
      fix_quality_seen = 1'b0;
    end else if (c == CHAR_STAR) begin
      sum_phase = sum_phase + 8'd1;
    end else begin
      if (sum_phase == PHASE_DATA) xor_sum = xor_sum ^ c;
      if (c == CHAR_COMMA) begin
        comma_total = comma_total + 8'd1;
        char_index = '0;
      end else if (sum_phase == PHASE_HIGH) begin
        rx_checksum = digit_value(c) << 4;
        sum_phase = PHASE_LOW;
      end else if (sum_phase == PHASE_LOW) begin
        rx_checksum = rx_checksum + digit_value(c);
        sum_phase = PHASE_DONE;
        st.checked = 1'b1;
        if (rx_checksum == xor_sum) begin
          st.match = 1'b1;
          if (cur_kind == KIND_RMC) rmc_fix = 1'b1;
          if (cur_kind == KIND_GGA) begin
            layout_ok = lat_chars[LAT_DOT_POS] == CHAR_DOT && lon_chars[LON_DOT_POS] == CHAR_DOT
                        && fix_quality_seen
                        && (lat_chars[LAT_HEM_POS] == CHAR_N || lat_chars[LAT_HEM_POS] == CHAR_S)
                        && (lon_chars[LON_HEM_POS] == CHAR_E || lon_chars[LON_HEM_POS] == CHAR_W);
            gga_fix = layout_ok;
          end
        end
      end else if (comma_total == 8'd0) begin
        if (c == CHAR_C) cur_kind = KIND_RMC;
        else if (c == CHAR_S || c == CHAR_Z || c == CHAR_V) cur_kind = KIND_IGNORED;
        else if (c == CHAR_A && cur_kind != KIND_IGNORED) cur_kind = KIND_GGA;
      end else if (char_index == FIELD_LIMIT) begin
        cur_kind = KIND_UNKNOWN;
        limit_aborts++;
      end else if (cur_kind == KIND_RMC) begin
        if (comma_total == RMC_SPEED_FIELD) begin
          st.target = TGT_SPEED;
          st.pos = take_index();
          st.ch = c;
        end else if (comma_total == RMC_COURSE_FIELD) begin
          st.target = TGT_COURSE;
          st.pos = take_index();
          st.ch = c;
        end else if (comma_total == RMC_END_FIELD) begin
          cur_kind = KIND_UNKNOWN;
        end
      end else if (cur_kind == KIND_GGA) begin
        case (comma_total)
          GGA_LAT_FIELD: begin
            st.target = TGT_LAT;
            st.pos = take_index();
            st.ch = c;
            if (st.pos < TEXT_DEPTH) lat_chars[st.pos] = c;
          end
          GGA_LAT_HEM_FIELD: begin
            st.target = TGT_LAT_HEM;
            st.pos = LAT_HEM_POS;
            st.ch = c;
            lat_chars[LAT_HEM_POS] = c;
          end
          GGA_LON_FIELD: begin
            st.target = TGT_LON;
            st.pos = take_index();
            st.ch = c;
            if (st.pos < TEXT_DEPTH) lon_chars[st.pos] = c;
          end
          GGA_LON_HEM_FIELD: begin
            st.target = TGT_LON_HEM;
            st.pos = LON_HEM_POS;
            st.ch = c;
            lon_chars[LON_HEM_POS] = c;
          end
          GGA_QUAL_FIELD: begin
            if (c == CHAR_ONE || c == CHAR_TWO || c == CHAR_THREE) fix_quality_seen = 1'b1;
          end
          GGA_SATS_FIELD: begin
            st.target = TGT_SATS;
            st.pos = take_index();
            st.ch = c;
          end
          GGA_END_FIELD: cur_kind = KIND_UNKNOWN;
          default: ;
        endcase
      end
    end
    st.kind = cur_kind;
    st.gga_valid = gga_fix;
    st.rmc_valid = rmc_fix;
    return st;
  endfunction

  // ---------------------------------------------------------------- idling

  function automatic int idle_length();
    return ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  function automatic int sender_gap_cycles();
    if (!sender_idles || $urandom_range(0, 99) < 65) return 0;
    return idle_length();
  endfunction

  task automatic choose_idling();
    sender_idles = $urandom_range(0, 2) != 0;
    receiver_idles = $urandom_range(0, 2) != 0;
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_requests != holds_served) begin
      holds_served <= hold_requests;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (receiver_idles && $urandom_range(0, 99) < 20) begin
      stall_left <= idle_length() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_status.size());
      $display("FAIL nmea_sentence_parser_unit");
      $finish;
    end
  end

  // ---------------------------------------------------------------- checking

  function automatic string status_text(input result_t s);
    return $sformatf("kind=%0d chk=%0b match=%0b gga=%0b rmc=%0b tgt=%0d pos=%0d char=%02h",
                     s.kind, s.checked, s.match, s.gga_valid, s.rmc_valid, s.target, s.pos,
                     s.ch);
  endfunction

  task automatic report_mismatch(input string what, input string want_txt);
    mismatch_total++;
    if (mismatch_total <= 10)
      $display("Mismatch on result %0d (%s): expected %s, got %s", results_checked, what,
               want_txt, status_text(seen_status));
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen_status.kind = kind_t'(sentence_kind);
      seen_status.checked = checksum_checked;
      seen_status.match = checksum_match;
      seen_status.gga_valid = gga_valid;
      seen_status.rmc_valid = rmc_valid;
      seen_status.target = target_t'(store_target);
      seen_status.pos = store_position;
      seen_status.ch = store_char;
      if (pending_status.size() == 0) begin
        report_mismatch("no result expected", "none");
      end else begin
        want_status = pending_status.pop_front();
        diff_fields = "";
        if (seen_status.kind !== want_status.kind) diff_fields = {diff_fields, " kind"};
        if (seen_status.checked !== want_status.checked) diff_fields = {diff_fields, " checked"};
        if (seen_status.match !== want_status.match) diff_fields = {diff_fields, " match"};
        if (seen_status.gga_valid !== want_status.gga_valid) diff_fields = {diff_fields, " gga"};
        if (seen_status.rmc_valid !== want_status.rmc_valid) diff_fields = {diff_fields, " rmc"};
        if (seen_status.target !== want_status.target) diff_fields = {diff_fields, " target"};
        if (seen_status.pos !== want_status.pos) diff_fields = {diff_fields, " position"};
        if (seen_status.ch !== want_status.ch) diff_fields = {diff_fields, " char"};
        if (diff_fields != "") report_mismatch(diff_fields, status_text(want_status));
      end
      results_checked++;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_byte(input logic [7:0] b, input logic err, input logic clr);
    int      gap;
    result_t st;
    gap = sender_gap_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    line_error <= err;
    clear_flags <= clr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    st = next_parser_status(b, err, clr);
    pending_status.push_back(st);
    bytes_sent++;
    if (st.match) checksum_hits++;
    if (st.match && st.gga_valid) gga_fixes++;
    if (st.match && st.rmc_valid) rmc_fixes++;
  endtask

  task automatic send_frame(input int err_pm, input int clr_pm);
    foreach (frame[i])
      send_byte(frame[i], $urandom_range(0, 999) < err_pm, $urandom_range(0, 999) < clr_pm);
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) frame.push_back(s[i]);
  endtask

  task automatic put_digits(input int n);
    repeat (n) frame.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
  endtask

  function automatic logic [7:0] field_char();
    int         r;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 70) return 8'(CHAR_ZERO + $urandom_range(0, 9));
    if (r < 85) return CHAR_DOT;
    if (r < 95) return 8'(CHAR_A + $urandom_range(0, 25));
    do c = 8'($urandom_range(0, 255));
    while (c == CHAR_DOLLAR || c == CHAR_STAR || c == CHAR_COMMA);
    return c;
  endfunction

  task automatic put_filler(input int n);
    repeat (n) frame.push_back(field_char());
  endtask

  task automatic start_sentence(input string id);
    frame.delete();
    frame.push_back(CHAR_DOLLAR);
    put_str(id);
    sentence_total++;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
    if (v < 4'd10) return 8'(CHAR_ZERO + v);
    return lower ? 8'(8'h57 + v) : 8'(8'h37 + v);
  endfunction

  // Append the star, the checksum (right or spoiled) and often CR LF.
  task automatic finish_sentence(input bit good);
    logic [7:0] sum;
    sum = '0;
    for (int i = 1; i < frame.size(); i++)
      if (frame[i] != CHAR_STAR) sum = sum ^ frame[i];
    frame.push_back(CHAR_STAR);
    if (good) begin
      frame.push_back(hex_char(sum[7:4], 1'b0));
      frame.push_back(hex_char(sum[3:0], 1'b0));
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          sum = sum ^ 8'($urandom_range(1, 255));
          frame.push_back(hex_char(sum[7:4], 1'b0));
          frame.push_back(hex_char(sum[3:0], 1'b0));
        end
        1: begin
          frame.push_back(hex_char(sum[7:4], 1'b1));
          frame.push_back(hex_char(sum[3:0], 1'b1));
        end
        2: begin
          frame.push_back(8'($urandom_range(0, 255)));
          frame.push_back(8'($urandom_range(0, 255)));
        end
        default: frame.push_back(hex_char(sum[7:4], 1'b0));
      endcase
    end
    if ($urandom_range(0, 9) < 7) begin
      frame.push_back(CHAR_CR);
      frame.push_back(CHAR_LF);
    end
  endtask

  task automatic put_position(input int whole);
    if ($urandom_range(0, 99) < 85) begin
      put_digits(whole);
      frame.push_back(CHAR_DOT);
      put_digits($urandom_range(1, 4));
    end else begin
      put_filler($urandom_range(0, 14));
    end
  endtask

  task automatic put_hemisphere(input logic [7:0] a, input logic [7:0] b);
    if ($urandom_range(0, 99) < 85) frame.push_back($urandom_range(0, 1) ? a : b);
    else put_filler($urandom_range(0, 2));
  endtask

  task automatic build_gga();
    start_sentence($urandom_range(0, 1) ? "GPGGA" : "GNGGA");
    put_str(","); put_digits(6); put_str(".00,");
    put_position(4); put_str(",");
    put_hemisphere(CHAR_N, CHAR_S); put_str(",");
    put_position(5); put_str(",");
    put_hemisphere(CHAR_E, CHAR_W); put_str(",");
    if ($urandom_range(0, 9) < 8) frame.push_back(8'(CHAR_ZERO + $urandom_range(0, 4)));
    else put_filler($urandom_range(0, 2));
    put_str(",");
    if ($urandom_range(0, 9) < 8) put_digits($urandom_range(0, 3));
    else put_filler($urandom_range(0, 13));
    put_str(",0.9,"); put_digits(3); put_str(",M,"); put_digits(2); put_str(",M,,0000");
    // A trailing extra field runs past the last GGA field.
    if ($urandom_range(0, 4) == 0) begin
      put_str(",");
      put_filler($urandom_range(1, 3));
    end
    finish_sentence($urandom_range(0, 9) < 8);
  endtask

  task automatic build_rmc();
    start_sentence($urandom_range(0, 1) ? "GPRMC" : "GNRMC");
    put_str(","); put_digits(6);
    put_str($urandom_range(0, 1) ? ",A," : ",V,");
    put_position(4); put_str(",N,");
    put_position(5); put_str(",E,");
    if ($urandom_range(0, 9) < 8) begin
      put_digits($urandom_range(1, 3)); put_str("."); put_digits($urandom_range(1, 2));
    end else begin
      put_filler($urandom_range(0, 13));
    end
    put_str(",");
    if ($urandom_range(0, 9) < 8) put_digits($urandom_range(1, 3));
    else put_filler($urandom_range(0, 13));
    put_str(","); put_digits(6); put_str(",,,A");
    if ($urandom_range(0, 4) == 0) begin
      put_str(",");
      put_filler($urandom_range(1, 3));
    end
    finish_sentence($urandom_range(0, 9) < 8);
  endtask

  task automatic build_other();
    case ($urandom_range(0, 6))
      0: start_sentence("GPGSV");
      1: start_sentence("GPGSA");
      2: start_sentence("GPVTG");
      3: start_sentence("GPZDA");
      4: start_sentence("GPGLL");
      5: start_sentence("GPTXT");
      default: begin
        start_sentence("");
        repeat (5) frame.push_back(8'(CHAR_A + $urandom_range(0, 25)));
      end
    endcase
    repeat ($urandom_range(0, 12)) begin
      put_str(",");
      put_filler($urandom_range(0, 6));
    end
    finish_sentence($urandom_range(0, 9) < 8);
  endtask

  task automatic build_noise();
    frame.delete();
    repeat ($urandom_range(1, 10)) frame.push_back(8'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_byte_extremes();
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'h00, 1'b1, 1'b1);
  endtask

  // Ignored letters lock out A but not C.
  task automatic test_kind_letters();
    start_sentence("SA"); finish_sentence(1'b1); send_frame(0, 0);
    start_sentence("ZC"); finish_sentence(1'b1); send_frame(0, 0);
    start_sentence("VA"); finish_sentence(1'b1); send_frame(0, 0);
  endtask

  task automatic test_minimal_fixes();
    start_sentence("A,,1234.5,N,12345.6,E,1"); finish_sentence(1'b1); send_frame(0, 0);
    send_byte(CHAR_A, 1'b0, 1'b1);
    start_sentence("C"); finish_sentence(1'b1); send_frame(0, 0);
    send_byte(CHAR_C, 1'b1, 1'b0);
    start_sentence("A,,1234.5,S,12345.6,W,2"); finish_sentence(1'b0); send_frame(0, 0);
  endtask

  task automatic test_field_limit();
    start_sentence("GPRMC,,,,,,,123456789012,5"); finish_sentence(1'b1); send_frame(0, 0);
    start_sentence("A,,1234567890123,N"); finish_sentence(1'b1); send_frame(0, 0);
  endtask

  task automatic test_sentence_end();
    start_sentence("C,,,,,,,,,,,,,1"); finish_sentence(1'b1); send_frame(0, 0);
    start_sentence("A,,,,,,,,,,,,,,,1"); finish_sentence(1'b1); send_frame(0, 0);
  endtask

  // 256 commas bring the count back to the ID field.
  task automatic test_comma_wrap();
    choose_idling();
    start_sentence("A");
    repeat (256) frame.push_back(CHAR_COMMA);
    put_str("C,,,,,,,12.5,77");
    finish_sentence(1'b1);
    send_frame(0, 0);
  endtask

  // 256 stars bring the checksum phase back to data.
  task automatic test_star_wrap();
    choose_idling();
    start_sentence("C");
    repeat (256) frame.push_back(CHAR_STAR);
    put_str(",1");
    finish_sentence(1'b1);
    send_frame(0, 0);
  endtask

  task automatic test_output_hold_off();
    sender_idles = 1'b0;
    hold_requests++;
    build_gga();
    send_frame(0, 0);
  endtask

  task automatic test_random_traffic();
    int start_count;
    int pick;
    int cut;
    start_count = bytes_sent;
    choose_idling();
    while (bytes_sent - start_count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 8) choose_idling();
      pick = $urandom_range(0, 99);
      if (pick < 35) build_gga();
      else if (pick < 65) build_rmc();
      else if (pick < 82) build_other();
      else build_noise();
      // Drop the tail of some sentences.
      if (pick < 82 && $urandom_range(0, 99) < 8) begin
        cut = $urandom_range(1, frame.size() - 1);
        while (frame.size() > cut) frame.delete(frame.size() - 1);
      end
      if (pick < 82) send_frame(3, 20);
      else send_frame(100, 100);
    end
    random_bytes = bytes_sent - start_count;
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    rx_byte = '0;
    line_error = 1'b0;
    clear_flags = 1'b0;
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    cur_kind = KIND_UNKNOWN;
    comma_total = '0;
    char_index = '0;
    sum_phase = PHASE_DATA;
    xor_sum = '0;
    rx_checksum = '0;
    fix_quality_seen = 1'b0;
    gga_fix = 1'b0;
    rmc_fix = 1'b0;
    foreach (lat_chars[i]) begin
      lat_chars[i] = '0;
      lon_chars[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_byte_extremes();
    test_kind_letters();
    test_minimal_fixes();
    test_field_limit();
    test_sentence_end();
    test_comma_wrap();
    test_star_wrap();
    test_output_hold_off();
    test_random_traffic();

    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes (%0d random) in %0d sentences; checked %0d results, %0d mismatches",
             bytes_sent, random_bytes, sentence_total, results_checked, mismatch_total);
    $display("Checksum matches %0d, GGA fixes %0d, RMC fixes %0d, field-limit aborts %0d",
             checksum_hits, gga_fixes, rmc_fixes, limit_aborts);
    if (mismatch_total == 0) begin
      $display("PASS nmea_sentence_parser_unit");
    end else begin
      $display("FAIL nmea_sentence_parser_unit");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/nmea_pkg.sv
rtl/nmea_sentence_parser_unit.sv
tb/tb_nmea_sentence_parser_unit.sv
